// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and constants for the SD card SPI command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    // Number of response bytes clocked after the command
    localparam int RESPONSE_BYTES = 10;
    // Number of idle bytes sent by a wake sequence
    localparam int WAKE_BYTES     = 10;

    // Opcodes of an input word
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_WAKE = 2'd2;

    // Engine modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CMD  = 2'd1;
    localparam logic [1:0] MODE_WAKE = 2'd2;

    // Byte positions within a command sequence
    localparam logic [4:0] FIRST_RESP = 5'd7;
    localparam logic [4:0] END_RESP   = 5'(7 + RESPONSE_BYTES);
    localparam logic [4:0] WAKE_LAST  = 5'(WAKE_BYTES - 1);

    localparam logic [7:0] CMD_START = 8'h40;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    // One input word
    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [7:0]  crc_byte;
        logic        miso_level;
    } t_item;

    // One result word
    typedef struct packed {
        logic       clock_pin;
        logic       data_out_pin;
        logic       select_n_pin;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] response_r1;
        logic       done_res;
    } t_result;

    // Byte sent at a given position of the command frame
    function automatic logic [7:0] command_byte(input logic [4:0]  idx,
                                                input logic [5:0]  cmd,
                                                input logic [31:0] arg,
                                                input logic [7:0]  crc);
        logic [7:0] b;
        unique case (idx)
            5'd1:    b = CMD_START | {2'b00, cmd};
            5'd2:    b = arg[31:24];
            5'd3:    b = arg[23:16];
            5'd4:    b = arg[15:8];
            5'd5:    b = arg[7:0];
            5'd6:    b = crc;
            default: b = IDLE_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sdspi_in_reg.sv =====
// ----------------------------------------------------------------------------
// sdspi_in_reg
// Input register: captures one word per cycle, stalls only when the
// downstream stage cannot advance.
// ----------------------------------------------------------------------------
module sdspi_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sdspi_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_valid,
    output sdspi_pkg::t_item o_item
);
    import sdspi_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Hold while the occupied stage cannot move on
    assign o_stall = r_valid && !i_advance;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/sdspi_engine.sv =====
// ----------------------------------------------------------------------------
// sdspi_engine
// Half-bit SPI mode 0 engine: state registers plus the single-pass next
// state and result logic for one word.
// ----------------------------------------------------------------------------
module sdspi_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sdspi_pkg::t_item   i_item,
    output sdspi_pkg::t_result o_result
);
    import sdspi_pkg::*;

    logic [1:0]  r_mode,     n_mode;
    logic        r_half,     n_half;
    logic [2:0]  r_bit,      n_bit;
    logic [4:0]  r_byte,     n_byte;
    logic [7:0]  r_send,     n_send;
    logic [7:0]  r_recv,     n_recv;
    logic [5:0]  r_cmd,      n_cmd;
    logic [31:0] r_arg,      n_arg;
    logic [7:0]  r_crc,      n_crc;
    logic [7:0]  r_r1,       n_r1;
    logic        r_sel_n,    n_sel_n;
    logic        r_clk_lvl,  n_clk_lvl;

    logic        byte_vld;
    logic [7:0]  byte_val;
    logic        done;
    logic        last;
    logic [4:0]  byte_inc;

    assign byte_inc = r_byte + 5'd1;

    // Next state for one word
    always_comb begin
        n_mode    = r_mode;
        n_half    = r_half;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_send    = r_send;
        n_recv    = r_recv;
        n_cmd     = r_cmd;
        n_arg     = r_arg;
        n_crc     = r_crc;
        n_r1      = r_r1;
        n_sel_n   = r_sel_n;
        n_clk_lvl = r_clk_lvl;
        byte_vld  = 1'b0;
        byte_val  = 8'h00;
        done      = 1'b0;
        last      = 1'b0;

        priority if (i_item.opcode == OP_CMD && r_mode == MODE_IDLE) begin
            n_cmd     = i_item.command_index;
            n_arg     = i_item.argument;
            n_crc     = i_item.crc_byte;
            n_r1      = IDLE_BYTE;
            n_mode    = MODE_CMD;
            n_half    = 1'b0;
            n_bit     = 3'd7;
            n_byte    = 5'd0;
            n_send    = IDLE_BYTE;
            n_recv    = 8'h00;
            n_clk_lvl = 1'b0;
            n_sel_n   = 1'b0;
        end else if (i_item.opcode == OP_WAKE && r_mode == MODE_IDLE) begin
            n_mode    = MODE_WAKE;
            n_half    = 1'b0;
            n_bit     = 3'd7;
            n_byte    = 5'd0;
            n_send    = IDLE_BYTE;
            n_recv    = 8'h00;
            n_clk_lvl = 1'b0;
            n_sel_n   = 1'b1;
        end else if (i_item.opcode == OP_TICK && r_mode != MODE_IDLE) begin
            if (!r_half) begin
                // rising edge: sample MISO
                n_clk_lvl = 1'b1;
                n_recv    = {r_recv[6:0], i_item.miso_level};
                n_half    = 1'b1;
            end else begin
                // falling edge: shift out next bit
                n_clk_lvl = 1'b0;
                n_half    = 1'b0;
                if (r_bit != 3'd0) begin
                    n_bit = r_bit - 3'd1;
                end else begin
                    if (r_mode == MODE_CMD && r_byte >= FIRST_RESP && r_byte < END_RESP) begin
                        byte_vld = 1'b1;
                        byte_val = r_recv;
                        if (r_r1 == IDLE_BYTE && !r_recv[7]) begin
                            n_r1 = r_recv;
                        end
                    end
                    if (r_mode == MODE_CMD) begin
                        last = (r_byte == END_RESP);
                    end else begin
                        last = (r_byte >= WAKE_LAST);
                    end
                    n_bit  = 3'd7;
                    n_recv = 8'h00;
                    if (last) begin
                        n_mode  = MODE_IDLE;
                        done    = 1'b1;
                        n_send  = IDLE_BYTE;
                        n_byte  = 5'd0;
                        n_sel_n = 1'b1;
                    end else begin
                        n_byte = byte_inc;
                        n_send = (r_mode == MODE_CMD) ?
                                 command_byte(byte_inc, r_cmd, r_arg, r_crc) : IDLE_BYTE;
                        // deselect as the trailing byte begins
                        if (r_mode == MODE_CMD && byte_inc == END_RESP) begin
                            n_sel_n = 1'b1;
                        end
                    end
                end
            end
        end else begin
            // ignored word: nothing changes
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_half    <= 1'b0;
            r_bit     <= 3'd7;
            r_byte    <= 5'd0;
            r_send    <= IDLE_BYTE;
            r_recv    <= 8'h00;
            r_cmd     <= 6'd0;
            r_arg     <= 32'd0;
            r_crc     <= 8'd0;
            r_r1      <= IDLE_BYTE;
            r_sel_n   <= 1'b1;
            r_clk_lvl <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_half    <= n_half;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_send    <= n_send;
            r_recv    <= n_recv;
            r_cmd     <= n_cmd;
            r_arg     <= n_arg;
            r_crc     <= n_crc;
            r_r1      <= n_r1;
            r_sel_n   <= n_sel_n;
            r_clk_lvl <= n_clk_lvl;
        end
    end

    // Result seen after this word
    always_comb begin
        o_result.clock_pin    = n_clk_lvl;
        o_result.data_out_pin = n_send[n_bit];
        o_result.select_n_pin = n_sel_n;
        o_result.busy_res     = (n_mode != MODE_IDLE);
        o_result.byte_valid   = byte_vld;
        o_result.byte_value   = byte_val;
        o_result.response_r1  = n_r1;
        o_result.done_res     = done;
    end

endmodule

// ===== rtl/sdspi_out_reg.sv =====
// ----------------------------------------------------------------------------
// sdspi_out_reg
// Result register: holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
module sdspi_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  sdspi_pkg::t_result i_result,
    input  logic               i_stall,
    output logic               o_advance,
    output logic               o_valid,
    output sdspi_pkg::t_result o_result
);
    import sdspi_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Register is free when empty or being drained
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/sd_spi_command_transaction_top.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_transaction_top
// SD card SPI mode 0 command engine driven by half-bit ticks.
// ----------------------------------------------------------------------------
// Each input word is a half-bit tick (carrying the sampled MISO level), a
// command start or a wake start, and produces exactly one result word with
// the SCK, MOSI and chip-select levels, busy/done flags, any completed
// response byte and the captured R1. The block takes one word per clock
// cycle while the receiver does not stall it. A taken word is held in the
// input register and worked by the single-pass engine out of it; its result
// is loaded into the result register once that register is free, and the
// outputs show it from there. Starts while busy, ticks while idle and opcode
// 3 leave the state untouched.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_command_index,
    input  logic [31:0] i_argument,
    input  logic [7:0]  i_crc_byte,
    input  logic        i_miso_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_clock_pin,
    output logic        o_data_out_pin,
    output logic        o_select_n_pin,
    output logic        o_busy_res,
    output logic        o_byte_valid,
    output logic [7:0]  o_byte_value,
    output logic [7:0]  o_response_r1,
    output logic        o_done_res
);
    import sdspi_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    advance;
    t_result eng_result;
    t_result out_result;

    assign in_item.opcode        = i_opcode;
    assign in_item.command_index = i_command_index;
    assign in_item.argument      = i_argument;
    assign in_item.crc_byte      = i_crc_byte;
    assign in_item.miso_level    = i_miso_level;

    sdspi_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_stall),
        .o_valid   (reg_valid),
        .o_item    (reg_item)
    );

    sdspi_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (reg_valid && advance),
        .i_item   (reg_item),
        .o_result (eng_result)
    );

    sdspi_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (reg_valid),
        .i_result     (eng_result),
        .i_stall      (i_stall),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_clock_pin    = out_result.clock_pin;
    assign o_data_out_pin = out_result.data_out_pin;
    assign o_select_n_pin = out_result.select_n_pin;
    assign o_busy_res     = out_result.busy_res;
    assign o_byte_valid   = out_result.byte_valid;
    assign o_byte_value   = out_result.byte_value;
    assign o_response_r1  = out_result.response_r1;
    assign o_done_res     = out_result.done_res;

endmodule

// ===== rtl/sdspi_checker.sv =====
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks for the SD SPI command engine, bound to the top level.
// ----------------------------------------------------------------------------
module sdspi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_stall,
    input logic       o_valid,
    input logic       o_clock_pin,
    input logic       o_data_out_pin,
    input logic       o_select_n_pin,
    input logic       o_busy_res,
    input logic       o_byte_valid,
    input logic [7:0] o_response_r1,
    input logic       o_done_res
);

    // A finished sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done word while still busy");

    // Response bytes arrive only mid-command, never on the closing word;
    // chip select may already rise as the last one completes
    a_byte_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> o_busy_res && !o_done_res)
        else $error("response byte outside a running command");

    // Idle bus rests with SCK low and MOSI high
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_clock_pin && o_data_out_pin)
        else $error("bus not at rest while idle");

    // A stalled word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_response_r1))
        else $error("stalled result word changed");

endmodule

bind sd_spi_command_transaction_top sdspi_checker u_sdspi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_stall        (i_stall),
    .o_valid        (o_valid),
    .o_clock_pin    (o_clock_pin),
    .o_data_out_pin (o_data_out_pin),
    .o_select_n_pin (o_select_n_pin),
    .o_busy_res     (o_busy_res),
    .o_byte_valid   (o_byte_valid),
    .o_response_r1  (o_response_r1),
    .o_done_res     (o_done_res)
);

// ===== tb/sd_spi_command_transaction_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_spi_command_transaction_top_tb
// Self-checking testbench for the SD card SPI command engine.
// ----------------------------------------------------------------------------
// A short directed opening covers ignored words: a tick while idle, the unused
// opcode, and starts while busy. It also sends a command start with all-ones
// fields. Random traffic follows: whole command and wake frames, where the
// MISO levels place an R1 byte at a random response slot or leave it out,
// with ignored words mixed in. A behavioral copy of the engine predicts every
// result word. A monitor compares each result word, field by field, with the
// oldest prediction. Sender gaps and receiver stalls vary by phase, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_top_tb;
    import sdspi_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         STIM_WORDS = 850;
    localparam int         HOLD_OFF   = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_TICK;
    logic [5:0]  i_command_index = '0;
    logic [31:0] i_argument = '0;
    logic [7:0]  i_crc_byte = '0;
    logic        i_miso_level = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_clock_pin;
    logic        o_data_out_pin;
    logic        o_select_n_pin;
    logic        o_busy_res;
    logic        o_byte_valid;
    logic [7:0]  o_byte_value;
    logic [7:0]  o_response_r1;
    logic        o_done_res;

    sd_spi_command_transaction_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_command_index (i_command_index),
        .i_argument      (i_argument),
        .i_crc_byte      (i_crc_byte),
        .i_miso_level    (i_miso_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_clock_pin     (o_clock_pin),
        .o_data_out_pin  (o_data_out_pin),
        .o_select_n_pin  (o_select_n_pin),
        .o_busy_res      (o_busy_res),
        .o_byte_valid    (o_byte_valid),
        .o_byte_value    (o_byte_value),
        .o_response_r1   (o_response_r1),
        .o_done_res      (o_done_res)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_item   pending_words[$];
    t_result expected_pins[$];
    t_item   next_word;
    t_item   taken_word;
    t_result want_in;
    t_result want_out;

    int   total_words = 0;
    int   live_words = 0;
    int   words_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   idle_phase = 0;
    int   frames_closed = 0;
    int   resp_bytes = 0;
    int   r1_found = 0;
    int   backpressure = 0;
    logic word_taken = 1'b0;
    logic hold_rx = 1'b0;

    // Run limit
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $display("timeout: %0d of %0d words taken, %0d results pending",
                 words_taken, total_words, expected_pins.size());
        $finish;
    end

    // Behavioral engine state
    logic [1:0]  eng_mode = MODE_IDLE;
    logic        eng_half = 1'b0;
    logic [2:0]  eng_bit = 3'd7;
    logic [4:0]  eng_byte = '0;
    logic [7:0]  eng_tx = IDLE_BYTE;
    logic [7:0]  eng_rx = '0;
    logic [5:0]  eng_cmd = '0;
    logic [31:0] eng_arg = '0;
    logic [7:0]  eng_crc = '0;
    logic [7:0]  eng_r1 = IDLE_BYTE;
    logic        eng_csn = 1'b1;
    logic        eng_sck = 1'b0;

    task automatic start_sequence(input logic [1:0] m);
        eng_mode = m;
        eng_half = 1'b0;
        eng_bit  = 3'd7;
        eng_byte = '0;
        eng_tx   = IDLE_BYTE;
        eng_rx   = '0;
        eng_sck  = 1'b0;
        eng_csn  = (m == MODE_CMD) ? 1'b0 : 1'b1;
    endtask

    // Advance the engine by one word and give the pin levels after it
    task automatic spi_engine_advance(input t_item w, output t_result r);
        logic       fire;
        logic       fin;
        logic       last;
        logic [7:0] got;
        fire = 1'b0;
        fin  = 1'b0;
        got  = '0;
        if (w.opcode == OP_CMD && eng_mode == MODE_IDLE) begin
            eng_cmd = w.command_index;
            eng_arg = w.argument;
            eng_crc = w.crc_byte;
            eng_r1  = IDLE_BYTE;
            start_sequence(MODE_CMD);
        end else if (w.opcode == OP_WAKE && eng_mode == MODE_IDLE) begin
            start_sequence(MODE_WAKE);
        end else if (w.opcode == OP_TICK && eng_mode != MODE_IDLE) begin
            if (!eng_half) begin
                // rising edge: sample MISO
                eng_sck  = 1'b1;
                eng_rx   = {eng_rx[6:0], w.miso_level};
                eng_half = 1'b1;
            end else begin
                // falling edge: next bit on MOSI
                eng_sck  = 1'b0;
                eng_half = 1'b0;
                if (eng_bit != 3'd0) begin
                    eng_bit = eng_bit - 3'd1;
                end else begin
                    if (eng_mode == MODE_CMD && eng_byte >= FIRST_RESP &&
                        eng_byte < END_RESP) begin
                        fire = 1'b1;
                        got  = eng_rx;
                        if (eng_r1 == IDLE_BYTE && !got[7]) eng_r1 = got;
                    end
                    if (eng_mode == MODE_CMD)
                        last = (eng_byte == END_RESP);
                    else
                        last = (int'(eng_byte) + 1 >= WAKE_BYTES);
                    eng_bit = 3'd7;
                    eng_rx  = '0;
                    if (last) begin
                        eng_mode = MODE_IDLE;
                        fin      = 1'b1;
                        eng_tx   = IDLE_BYTE;
                        eng_byte = '0;
                        eng_csn  = 1'b1;
                    end else begin
                        eng_byte = eng_byte + 5'd1;
                        eng_tx   = IDLE_BYTE;
                        if (eng_mode == MODE_CMD) begin
                            case (eng_byte)
                                5'd1: eng_tx = CMD_START | {2'b00, eng_cmd};
                                5'd2: eng_tx = eng_arg[31:24];
                                5'd3: eng_tx = eng_arg[23:16];
                                5'd4: eng_tx = eng_arg[15:8];
                                5'd5: eng_tx = eng_arg[7:0];
                                5'd6: eng_tx = eng_crc;
                                default: eng_tx = IDLE_BYTE;
                            endcase
                            // trailing byte goes out deselected
                            if (eng_byte == END_RESP) eng_csn = 1'b1;
                        end
                    end
                end
            end
        end
        r.clock_pin    = eng_sck;
        r.data_out_pin = eng_tx[eng_bit];
        r.select_n_pin = eng_csn;
        r.busy_res     = (eng_mode != MODE_IDLE);
        r.byte_valid   = fire;
        r.byte_value   = got;
        r.response_r1  = eng_r1;
        r.done_res     = fin;
    endtask

    task automatic push_word(input logic [1:0] op, input logic [5:0] cmd,
                             input logic [31:0] arg, input logic [7:0] crc,
                             input logic miso);
        t_item w;
        w.opcode        = op;
        w.command_index = cmd;
        w.argument      = arg;
        w.crc_byte      = crc;
        w.miso_level    = miso;
        pending_words.push_back(w);
    endtask

    // A word the engine ignores: a start or opcode 3 while busy,
    // a tick or opcode 3 while idle
    task automatic push_ignored(input logic engaged);
        logic [1:0] op;
        if (engaged)
            op = ($urandom_range(2) == 0) ? OP_CMD :
                 ($urandom_range(1) == 0) ? OP_WAKE : OP_UNUSED;
        else
            op = ($urandom_range(1) == 0) ? OP_TICK : OP_UNUSED;
        push_word(op, 6'($urandom), $urandom, 8'($urandom), 1'($urandom));
    endtask

    // Ticks for a frame from byte first_byte on; MISO carries an R1 byte
    // at a random response slot, or none at all
    task automatic push_frame(input logic is_cmd, input int first_byte);
        int         nbytes;
        int         r1_at;
        int         k;
        logic [7:0] rb;
        nbytes = is_cmd ? int'(END_RESP) + 1 : WAKE_BYTES;
        r1_at  = $urandom_range(RESPONSE_BYTES);
        for (int b = first_byte; b < nbytes; b++) begin
            rb = 8'($urandom);
            if (is_cmd && b >= int'(FIRST_RESP) && b < int'(END_RESP)) begin
                k = b - int'(FIRST_RESP);
                if (k < r1_at)
                    rb = ($urandom_range(3) == 0) ? (rb | 8'h80) : IDLE_BYTE;
                else if (k == r1_at)
                    rb[7] = 1'b0;
            end
            for (int i = 7; i >= 0; i--) begin
                push_word(OP_TICK, 6'($urandom), $urandom, 8'($urandom), rb[i]);
                if ($urandom_range(39) == 0) push_ignored(1'b1);
                push_word(OP_TICK, 6'($urandom), $urandom, 8'($urandom),
                          1'($urandom));
                live_words += 2;
            end
        end
    endtask

    // Word driver
    always @(negedge i_clk) begin : drive_words
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 26 : (idle_phase == 1) ? 64 : 0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
                next_word = pending_words.pop_front();
                i_valid         <= 1'b1;
                i_opcode        <= next_word.opcode;
                i_command_index <= next_word.command_index;
                i_argument      <= next_word.argument;
                i_crc_byte      <= next_word.crc_byte;
                i_miso_level    <= next_word.miso_level;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall
    always @(negedge i_clk) begin : drive_stall
        int stall_pct;
        stall_pct = (idle_phase == 0) ? 64 : (idle_phase == 1) ? 26 : 0;
        i_stall <= hold_rx || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off so the block fills and pushes back
    initial begin
        wait (words_taken >= 150);
        @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (HOLD_OFF) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // Input side: predict each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            taken_word.opcode        = i_opcode;
            taken_word.command_index = i_command_index;
            taken_word.argument      = i_argument;
            taken_word.crc_byte      = i_crc_byte;
            taken_word.miso_level    = i_miso_level;
            spi_engine_advance(taken_word, want_in);
            expected_pins.push_back(want_in);
            words_taken++;
            word_taken = 1'b1;
            idle_phase = (words_taken * 3) / (total_words + 1);
        end
        if (i_rst_n && i_valid && o_stall) backpressure++;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic compare_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v)
            log_mismatch($sformatf("%s expected 0x%0h got 0x%0h", what, want_v, got_v));
    endtask

    // Output side: compare with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_pins.size() == 0) begin
                log_mismatch("result word with nothing expected");
            end else begin
                want_out = expected_pins.pop_front();
                compare_field("clock_pin", int'(want_out.clock_pin), int'(o_clock_pin));
                compare_field("data_out_pin", int'(want_out.data_out_pin),
                              int'(o_data_out_pin));
                compare_field("select_n_pin", int'(want_out.select_n_pin),
                              int'(o_select_n_pin));
                compare_field("busy_res", int'(want_out.busy_res), int'(o_busy_res));
                compare_field("byte_valid", int'(want_out.byte_valid), int'(o_byte_valid));
                compare_field("byte_value", int'(want_out.byte_value), int'(o_byte_value));
                compare_field("response_r1", int'(want_out.response_r1),
                              int'(o_response_r1));
                compare_field("done_res", int'(want_out.done_res), int'(o_done_res));
                if (want_out.byte_valid) resp_bytes++;
                if (want_out.done_res) begin
                    frames_closed++;
                    if (want_out.response_r1 != IDLE_BYTE) r1_found++;
                end
            end
        end
    end

    // Stimulus, reset and wrap-up
    initial begin
        // ignored words while idle
        push_word(OP_TICK, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        push_word(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // command with all-ones fields
        push_word(OP_CMD, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        // starts and opcode 3 while busy are dropped
        push_word(OP_CMD, 6'h00, 32'h0000_0000, 8'h00, 1'b1);
        push_word(OP_WAKE, 6'h00, 32'h0000_0000, 8'h00, 1'b0);
        push_word(OP_UNUSED, 6'h15, 32'hA5A5_5A5A, 8'h3C, 1'b1);
        // first frame byte, alternating MISO
        for (int i = 0; i < 16; i++)
            push_word(OP_TICK, '0, '0, '0, 1'(i >> 1));

        // finish that command, then a wake (R1 must survive it),
        // then a command with all-zero fields
        push_frame(1'b1, 1);
        push_word(OP_WAKE, 6'($urandom), $urandom, 8'($urandom), 1'($urandom));
        push_frame(1'b0, 0);
        push_word(OP_CMD, 6'h00, 32'h0000_0000, 8'h00, 1'b0);
        push_frame(1'b1, 0);
        live_words += 2;

        while (live_words < STIM_WORDS) begin
            if ($urandom_range(99) < 65) begin
                push_word(OP_CMD, 6'($urandom), $urandom, 8'($urandom), 1'($urandom));
                push_frame(1'b1, 0);
            end else begin
                push_word(OP_WAKE, 6'($urandom), $urandom, 8'($urandom), 1'($urandom));
                push_frame(1'b0, 0);
            end
            live_words++;
            repeat ($urandom_range(3)) push_ignored(1'b0);
        end
        total_words = pending_words.size();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (words_taken == total_words && expected_pins.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d words: %0d frames closed, %0d response bytes, %0d R1 captures",
                 words_taken, frames_closed, resp_bytes, r1_found);
        $display("input held off on %0d cycles, %0d mismatches", backpressure, mismatches);
        if (mismatches == 0 && expected_pins.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sdspi_pkg.sv
rtl/sdspi_in_reg.sv
rtl/sdspi_engine.sv
rtl/sdspi_out_reg.sv
rtl/sd_spi_command_transaction_top.sv
rtl/sdspi_checker.sv
tb/sd_spi_command_transaction_top_tb.sv
